// ===== sv/asdd_pkg.sv =====
// Shared types, constants and helpers for the AppleSingle/AppleDouble deframer.
package asdd_pkg;

  localparam int unsigned HDR_LEN = 26;
  localparam int unsigned ENT_LEN = 12;
  localparam int unsigned ENT_W   = 96;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHK,
    ST_EMIT,
    ST_REP_RD,
    ST_REP_WR
  } state_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TABLE,
    PH_LOOKUP,
    PH_PART,
    PH_PASS
  } phase_t;

  localparam logic [2:0] RT_HEADER   = 3'd0;
  localparam logic [2:0] RT_SKIP     = 3'd1;
  localparam logic [2:0] RT_DATA     = 3'd2;
  localparam logic [2:0] RT_RESOURCE = 3'd3;
  localparam logic [2:0] RT_COMMENT  = 3'd4;
  localparam logic [2:0] RT_DATES    = 3'd5;
  localparam logic [2:0] RT_FINDER   = 3'd6;
  localparam logic [2:0] RT_PASS     = 3'd7;

  localparam logic [31:0] ID_DATA     = 32'd1;
  localparam logic [31:0] ID_RESOURCE = 32'd2;
  localparam logic [31:0] ID_COMMENT  = 32'd4;
  localparam logic [31:0] ID_DATES    = 32'd8;
  localparam logic [31:0] ID_FINDER   = 32'd9;

  localparam logic [7:0] MAGIC_LAST_SINGLE = 8'h00;
  localparam logic [7:0] MAGIC_LAST_DOUBLE = 8'h07;

  // Expected header byte for positions 0..23 except the last magic byte (3).
  function automatic logic [7:0] hdr_expect(input logic [4:0] idx);
    logic [7:0] v;
    v = 8'h00;
    unique case (idx)
      5'd1:    v = 8'h05;
      5'd2:    v = 8'h16;
      5'd5:    v = 8'h02;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] route_of(input logic [31:0] id);
    logic [2:0] r;
    r = RT_SKIP;
    if (id == ID_DATA)          r = RT_DATA;
    else if (id == ID_RESOURCE) r = RT_RESOURCE;
    else if (id == ID_COMMENT)  r = RT_COMMENT;
    else if (id == ID_DATES)    r = RT_DATES;
    else if (id == ID_FINDER)   r = RT_FINDER;
    return r;
  endfunction

endpackage

// ===== sv/asdd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module asdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/applesingle_double_deframer.sv =====
// AppleSingle / AppleDouble deframer: one input byte per transaction on the s_ side,
// tagged bytes out on the m_ side.
// s_tdata carries the byte, s_tuser[0] restarts parsing with that byte as a new file.
// The first 25 header bytes produce nothing; the 26th replays all 26 stored bytes
// (route 0 if accepted, route 7 if rejected), read from the header RAM. Table bytes
// and bytes inside a part come out in the cycle after acceptance, one per cycle
// while m_tready stays high. A byte at a part boundary scans the entry RAM entry by
// entry until a match or the table's last entry, before its transaction goes out.
// The last transaction caused by each input byte carries m_tlast.
// Status flags in m_tdata show the parse state after the byte was taken.
// One output register separates the sides: a plain byte is taken while the previous
// transaction is still waiting, as long as that one is being drained in the same cycle.
// When m_tready is low the output holds and s_tready drops.
// Synchronous reset returns to the header phase; the RAMs need no clearing, as
// entries are read only after being written.
module applesingle_double_deframer #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_tuser,   // [0] start_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] out_byte, [39:8] part_position, [40] header_ok,
                                 // [41] data_fork_done, [42] resource_fork_done,
                                 // [43] table_overflow, [47:44] zero
  output logic [2:0]  m_tuser,   // [2:0] route
  output logic        m_tlast
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = asdd_pkg::ENT_W;

  asdd_pkg::state_t state, state_next;
  asdd_pkg::phase_t phase, phase_next;

  logic [4:0]    fill, fill_next;
  logic          hdr_bad, hdr_bad_next;
  logic          magic_dbl, magic_dbl_next;
  logic [7:0]    cnt_hi, cnt_hi_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic          is_double, is_double_next;
  logic [EW-1:0] ent_sr, ent_sr_next;
  logic [IW-1:0] ent_idx, ent_idx_next;
  logic [3:0]    ent_byte, ent_byte_next;
  logic [31:0]   stream_offset, stream_offset_next;
  logic [31:0]   data_fork_start, data_fork_start_next;
  logic [2:0]    current_route, current_route_next;
  logic [31:0]   part_size, part_size_next;
  logic [31:0]   part_done, part_done_next;
  logic [31:0]   data_written, data_written_next;
  logic [31:0]   resource_written, resource_written_next;
  logic          table_loaded, table_loaded_next;
  logic          overflow, overflow_next;
  logic          has_data, has_data_next;
  logic [31:0]   data_size, data_size_next;
  logic          has_res, has_res_next;
  logic [31:0]   res_size, res_size_next;
  logic [7:0]    byte_hold, byte_hold_next;
  logic [IW-1:0] scan_idx, scan_idx_next;
  logic [4:0]    rep_idx, rep_idx_next;
  logic [2:0]    rep_route, rep_route_next;
  logic          skip, skip_next;

  logic          out_load;
  logic [7:0]    out_byte;
  logic [2:0]    out_route;
  logic [31:0]   out_pos;
  logic          out_last;
  logic [7:0]    o_byte;
  logic [2:0]    o_route;
  logic [31:0]   o_pos;
  logic          o_hok, o_dok, o_rok, o_ovf;
  logic          f_dok, f_rok;

  logic          hdr_we;
  logic [4:0]    hdr_waddr;
  logic [4:0]    hdr_raddr;
  logic [7:0]    hdr_rdata;
  logic          ent_we;
  logic [IW-1:0] ent_raddr;
  logic [EW-1:0] ent_rdata;

  logic          acc, ofree;
  logic [7:0]    b;
  logic [15:0]   cnt;
  logic          hok;
  logic [31:0]   e_kind, e_start, e_size, e_end;
  logic [31:0]   r_kind, r_start, r_size;

  assign ofree    = !m_tvalid || m_tready;
  assign s_tready = (state == asdd_pkg::ST_IDLE) && ofree;
  assign acc      = s_tvalid && s_tready;
  assign b        = s_tdata;

  assign r_kind  = ent_rdata[95:64];
  assign r_start = ent_rdata[63:32];
  assign r_size  = ent_rdata[31:0];

  asdd_ram #(.WIDTH(8), .DEPTH(asdd_pkg::HDR_LEN)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (b),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  asdd_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_idx),
    .wdata (ent_sr_next),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      asdd_pkg::ST_IDLE: begin
        if (acc) begin
          if (s_tuser[0]) begin
            state_next = (fill == 5'd0 && 5'(asdd_pkg::HDR_LEN - 1) == 5'd0) ?
                         asdd_pkg::ST_REP_RD : asdd_pkg::ST_IDLE;
          end else if (phase == asdd_pkg::PH_HEADER &&
                       fill == 5'(asdd_pkg::HDR_LEN - 1)) begin
            state_next = asdd_pkg::ST_REP_RD;
          end else if (phase == asdd_pkg::PH_LOOKUP) begin
            state_next = asdd_pkg::ST_SCAN;
          end
        end
      end
      asdd_pkg::ST_SCAN: state_next = asdd_pkg::ST_CHK;
      asdd_pkg::ST_CHK: begin
        if ((r_start == stream_offset && r_size != 32'd0) ||
            CW'(scan_idx) == entry_count - CW'(1)) begin
          state_next = asdd_pkg::ST_EMIT;
        end else begin
          state_next = asdd_pkg::ST_SCAN;
        end
      end
      asdd_pkg::ST_EMIT: begin
        if (ofree) state_next = asdd_pkg::ST_IDLE;
      end
      asdd_pkg::ST_REP_RD: state_next = asdd_pkg::ST_REP_WR;
      asdd_pkg::ST_REP_WR: begin
        if (ofree) begin
          state_next = (rep_idx == 5'(asdd_pkg::HDR_LEN - 1)) ?
                       asdd_pkg::ST_IDLE : asdd_pkg::ST_REP_RD;
        end
      end
      default: state_next = asdd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output loading.
  always_comb begin
    phase_next            = phase;
    fill_next             = fill;
    hdr_bad_next          = hdr_bad;
    magic_dbl_next        = magic_dbl;
    cnt_hi_next           = cnt_hi;
    entry_count_next      = entry_count;
    is_double_next        = is_double;
    ent_sr_next           = ent_sr;
    ent_idx_next          = ent_idx;
    ent_byte_next         = ent_byte;
    stream_offset_next    = stream_offset;
    data_fork_start_next  = data_fork_start;
    current_route_next    = current_route;
    part_size_next        = part_size;
    part_done_next        = part_done;
    data_written_next     = data_written;
    resource_written_next = resource_written;
    table_loaded_next     = table_loaded;
    overflow_next         = overflow;
    has_data_next         = has_data;
    data_size_next        = data_size;
    has_res_next          = has_res;
    res_size_next         = res_size;
    byte_hold_next        = byte_hold;
    scan_idx_next         = scan_idx;
    rep_idx_next          = rep_idx;
    rep_route_next        = rep_route;
    skip_next             = skip;
    out_load  = 1'b0;
    o_byte    = b;
    o_route   = asdd_pkg::RT_HEADER;
    o_pos     = stream_offset;
    hdr_we    = 1'b0;
    hdr_waddr = fill;
    hdr_raddr = rep_idx;
    ent_we    = 1'b0;
    ent_raddr = scan_idx;
    cnt       = 16'd0;
    hok       = 1'b0;
    e_kind    = 32'd0;
    e_start   = 32'd0;
    e_size    = 32'd0;
    e_end     = 32'd0;

    unique case (state)
      asdd_pkg::ST_IDLE: begin
        if (acc) begin
          if (s_tuser[0]) begin
            phase_next            = asdd_pkg::PH_HEADER;
            fill_next             = 5'd0;
            entry_count_next      = '0;
            is_double_next        = 1'b0;
            stream_offset_next    = 32'd0;
            data_fork_start_next  = 32'd0;
            current_route_next    = asdd_pkg::RT_HEADER;
            part_size_next        = 32'd0;
            part_done_next        = 32'd0;
            data_written_next     = 32'd0;
            resource_written_next = 32'd0;
            table_loaded_next     = 1'b0;
            overflow_next         = 1'b0;
            has_data_next         = 1'b0;
            has_res_next          = 1'b0;
          end
          o_pos = stream_offset_next;
          unique case (phase_next)
            asdd_pkg::PH_HEADER: begin
              hdr_we    = 1'b1;
              hdr_waddr = fill_next;
              if (fill_next == 5'd0) hdr_bad_next = 1'b0;
              if (fill_next == 5'd3) begin
                magic_dbl_next = (b == asdd_pkg::MAGIC_LAST_DOUBLE);
                if (b != asdd_pkg::MAGIC_LAST_SINGLE && b != asdd_pkg::MAGIC_LAST_DOUBLE)
                  hdr_bad_next = 1'b1;
              end else if (fill_next == 5'd24) begin
                cnt_hi_next = b;
              end else if (fill_next < 5'd24) begin
                if (b != asdd_pkg::hdr_expect(fill_next)) hdr_bad_next = 1'b1;
              end
              if (fill_next == 5'(asdd_pkg::HDR_LEN - 1)) begin
                cnt = {cnt_hi_next, b};
                hok = !hdr_bad_next && cnt != 16'd0;
                if (hok && 32'(cnt) > 32'(MAX_ENTRIES)) begin
                  hok           = 1'b0;
                  overflow_next = 1'b1;
                end
                fill_next = 5'd0;
                if (hok) begin
                  entry_count_next     = CW'(cnt);
                  is_double_next       = magic_dbl_next;
                  phase_next           = asdd_pkg::PH_TABLE;
                  ent_idx_next         = '0;
                  ent_byte_next        = 4'd0;
                  data_fork_start_next = 32'd0;
                  rep_route_next       = asdd_pkg::RT_HEADER;
                end else begin
                  phase_next     = asdd_pkg::PH_PASS;
                  rep_route_next = asdd_pkg::RT_PASS;
                end
                rep_idx_next = 5'd0;
              end else begin
                fill_next = fill_next + 5'd1;
              end
              stream_offset_next = stream_offset_next + 32'd1;
            end
            asdd_pkg::PH_TABLE: begin
              ent_sr_next = {ent_sr[EW-9:0], b};
              e_kind  = ent_sr_next[95:64];
              e_start = ent_sr_next[63:32];
              e_size  = ent_sr_next[31:0];
              e_end   = e_start + e_size;
              if (ent_byte == 4'(asdd_pkg::ENT_LEN - 1)) begin
                ent_we        = 1'b1;
                ent_byte_next = 4'd0;
                if (is_double && e_end > data_fork_start) data_fork_start_next = e_end;
                if (!has_data && e_kind == asdd_pkg::ID_DATA) begin
                  has_data_next  = 1'b1;
                  data_size_next = e_size;
                end
                if (!has_res && e_kind == asdd_pkg::ID_RESOURCE) begin
                  has_res_next  = 1'b1;
                  res_size_next = e_size;
                end
                if (CW'(ent_idx) == entry_count - CW'(1)) begin
                  table_loaded_next = 1'b1;
                  phase_next        = asdd_pkg::PH_LOOKUP;
                end else begin
                  ent_idx_next = ent_idx + IW'(1);
                end
              end else begin
                ent_byte_next = ent_byte + 4'd1;
              end
              out_load           = 1'b1;
              o_route            = asdd_pkg::RT_HEADER;
              stream_offset_next = stream_offset + 32'd1;
            end
            asdd_pkg::PH_LOOKUP: begin
              byte_hold_next = b;
              scan_idx_next  = '0;
            end
            asdd_pkg::PH_PART: begin
              out_load       = 1'b1;
              o_route        = current_route;
              o_pos          = part_done;
              part_done_next = part_done + 32'd1;
              if (current_route == asdd_pkg::RT_DATA)
                data_written_next = data_written + 32'd1;
              else if (current_route == asdd_pkg::RT_RESOURCE)
                resource_written_next = resource_written + 32'd1;
              if (!(current_route == asdd_pkg::RT_DATA && is_double) &&
                  part_done_next == part_size)
                phase_next = asdd_pkg::PH_LOOKUP;
              stream_offset_next = stream_offset + 32'd1;
            end
            default: begin
              phase_next         = asdd_pkg::PH_PASS;
              out_load           = 1'b1;
              o_route            = asdd_pkg::RT_PASS;
              stream_offset_next = stream_offset_next + 32'd1;
            end
          endcase
        end
      end
      asdd_pkg::ST_SCAN: begin
        ent_raddr = scan_idx;
      end
      asdd_pkg::ST_CHK: begin
        if (r_start == stream_offset && r_size != 32'd0) begin
          current_route_next = asdd_pkg::route_of(r_kind);
          part_size_next     = r_size;
          part_done_next     = 32'd0;
          phase_next         = asdd_pkg::PH_PART;
          skip_next          = 1'b0;
        end else if (CW'(scan_idx) == entry_count - CW'(1)) begin
          if (stream_offset == data_fork_start) begin
            current_route_next = asdd_pkg::RT_DATA;
            part_size_next     = 32'hFFFF_FFFF;
            part_done_next     = 32'd0;
            phase_next         = asdd_pkg::PH_PART;
            skip_next          = 1'b0;
          end else begin
            skip_next = 1'b1;
          end
        end else begin
          scan_idx_next = scan_idx + IW'(1);
        end
      end
      asdd_pkg::ST_EMIT: begin
        if (ofree) begin
          out_load           = 1'b1;
          o_byte             = byte_hold;
          stream_offset_next = stream_offset + 32'd1;
          if (skip) begin
            o_route = asdd_pkg::RT_SKIP;
            o_pos   = 32'd0;
          end else begin
            o_route        = current_route;
            o_pos          = part_done;
            part_done_next = part_done + 32'd1;
            if (current_route == asdd_pkg::RT_DATA)
              data_written_next = data_written + 32'd1;
            else if (current_route == asdd_pkg::RT_RESOURCE)
              resource_written_next = resource_written + 32'd1;
            if (!(current_route == asdd_pkg::RT_DATA && is_double) &&
                part_done_next == part_size)
              phase_next = asdd_pkg::PH_LOOKUP;
          end
        end
      end
      asdd_pkg::ST_REP_RD: begin
        hdr_raddr = rep_idx;
      end
      asdd_pkg::ST_REP_WR: begin
        if (ofree) begin
          out_load     = 1'b1;
          o_byte       = hdr_rdata;
          o_route      = rep_route;
          o_pos        = 32'(rep_idx);
          rep_idx_next = rep_idx + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Flags as they stand after this byte's step.
  always_comb begin
    f_dok = table_loaded_next &&
            (is_double_next || !has_data_next || data_written_next == data_size_next);
    f_rok = table_loaded_next && has_res_next && resource_written_next == res_size_next;
  end

  // tlast marks the last transaction of a step; replay ends on its final byte.
  always_comb begin
    out_last = 1'b1;
    if (state == asdd_pkg::ST_REP_WR && rep_idx != 5'(asdd_pkg::HDR_LEN - 1))
      out_last = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= asdd_pkg::ST_IDLE;
      phase            <= asdd_pkg::PH_HEADER;
      fill             <= 5'd0;
      hdr_bad          <= 1'b0;
      magic_dbl        <= 1'b0;
      entry_count      <= '0;
      is_double        <= 1'b0;
      ent_idx          <= '0;
      ent_byte         <= 4'd0;
      stream_offset    <= 32'd0;
      data_fork_start  <= 32'd0;
      current_route    <= asdd_pkg::RT_HEADER;
      part_size        <= 32'd0;
      part_done        <= 32'd0;
      data_written     <= 32'd0;
      resource_written <= 32'd0;
      table_loaded     <= 1'b0;
      overflow         <= 1'b0;
      has_data         <= 1'b0;
      has_res          <= 1'b0;
      scan_idx         <= '0;
      rep_idx          <= 5'd0;
      skip             <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      state            <= state_next;
      phase            <= phase_next;
      fill             <= fill_next;
      hdr_bad          <= hdr_bad_next;
      magic_dbl        <= magic_dbl_next;
      entry_count      <= entry_count_next;
      is_double        <= is_double_next;
      ent_idx          <= ent_idx_next;
      ent_byte         <= ent_byte_next;
      stream_offset    <= stream_offset_next;
      data_fork_start  <= data_fork_start_next;
      current_route    <= current_route_next;
      part_size        <= part_size_next;
      part_done        <= part_done_next;
      data_written     <= data_written_next;
      resource_written <= resource_written_next;
      table_loaded     <= table_loaded_next;
      overflow         <= overflow_next;
      has_data         <= has_data_next;
      has_res          <= has_res_next;
      scan_idx         <= scan_idx_next;
      rep_idx          <= rep_idx_next;
      skip             <= skip_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cnt_hi    <= cnt_hi_next;
    ent_sr    <= ent_sr_next;
    data_size <= data_size_next;
    res_size  <= res_size_next;
    byte_hold <= byte_hold_next;
    rep_route <= rep_route_next;
    if (out_load) begin
      out_byte  <= o_byte;
      out_route <= o_route;
      out_pos   <= o_pos;
      m_tlast   <= out_last;
      o_hok     <= table_loaded_next;
      o_dok     <= f_dok;
      o_rok     <= f_rok;
      o_ovf     <= overflow_next;
    end
  end

  assign m_tdata = {4'd0, o_ovf, o_rok, o_dok, o_hok, out_pos, out_byte};
  assign m_tuser = out_route;

endmodule

// ===== sv/asdd_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
module asdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_ok_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[40] && m_tdata[43]))
    else $error("table loaded together with overflow");

  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[41] || m_tdata[42]) |-> m_tdata[40])
    else $error("fork done without loaded table");

endmodule

bind applesingle_double_deframer asdd_checker u_asdd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/tb_applesingle_double_deframer.sv =====
// Self-checking testbench for the AppleSingle/AppleDouble deframer.
`timescale 1ns / 100ps

module tb_applesingle_double_deframer;

  localparam int MAXE = 16;
  localparam int unsigned MAGIC_S = 32'h00051600;
  localparam int unsigned MAGIC_D = 32'h00051607;
  localparam int unsigned VERSION = 32'h00020000;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [2:0]  route;
    logic [31:0] pos;
    logic        last;
    logic        hok;
    logic        dok;
    logic        rok;
    logic        ovf;
  } tagged_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;

  applesingle_double_deframer #(.MAX_ENTRIES(MAXE)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  byte_item_t   pending_bytes[$];
  tagged_byte_t expected_bytes[$];
  int errors = 0;
  int bytes_out = 0;
  int files_sent = 0;
  longint cycles = 0;
  bit stim_done = 0;

  // predictor state
  asdd_pkg::phase_t p_phase;
  logic [7:0]  p_hdr[asdd_pkg::HDR_LEN];
  int unsigned p_fill, p_count;
  bit          p_double, p_loaded, p_ovf;
  logic [31:0] p_kind[MAXE], p_start[MAXE], p_size[MAXE];
  logic [31:0] p_offset, p_dstart, p_psize, p_pdone, p_dwritten, p_rwritten;
  logic [2:0]  p_route;

  function automatic logic [2:0] kind_route(logic [31:0] id);
    case (id)
      asdd_pkg::ID_DATA:     return asdd_pkg::RT_DATA;
      asdd_pkg::ID_RESOURCE: return asdd_pkg::RT_RESOURCE;
      asdd_pkg::ID_COMMENT:  return asdd_pkg::RT_COMMENT;
      asdd_pkg::ID_DATES:    return asdd_pkg::RT_DATES;
      asdd_pkg::ID_FINDER:   return asdd_pkg::RT_FINDER;
      default:               return asdd_pkg::RT_SKIP;
    endcase
  endfunction

  task automatic clear_parse();
    p_phase = asdd_pkg::PH_HEADER;
    p_fill = 0; p_count = 0; p_double = 0; p_loaded = 0; p_ovf = 0;
    p_offset = 0; p_dstart = 0; p_route = asdd_pkg::RT_HEADER; p_psize = 0; p_pdone = 0;
    p_dwritten = 0; p_rwritten = 0;
    for (int i = 0; i < MAXE; i++) begin
      p_kind[i] = 0; p_start[i] = 0; p_size[i] = 0;
    end
  endtask

  task automatic predict_byte(byte_item_t it);
    tagged_byte_t outs[$];
    tagged_byte_t t;
    logic [31:0] magic, tofs, endv;
    int unsigned cnt, e, f;
    bit ok, found, seen_d, seen_r, dok, rok;
    if (it.sof) clear_parse();
    t = '0;
    case (p_phase)
      asdd_pkg::PH_HEADER: begin
        if (p_fill >= asdd_pkg::HDR_LEN) p_fill = 0;
        p_hdr[p_fill] = it.data;
        p_fill++;
        if (p_fill == asdd_pkg::HDR_LEN) begin
          magic = {p_hdr[0], p_hdr[1], p_hdr[2], p_hdr[3]};
          cnt = 32'({p_hdr[24], p_hdr[25]});
          ok = (magic == MAGIC_S || magic == MAGIC_D) &&
               {p_hdr[4], p_hdr[5], p_hdr[6], p_hdr[7]} == VERSION && cnt != 0;
          for (int i = 8; i < 24; i++) if (p_hdr[i] != 0) ok = 0;
          if (ok && cnt > MAXE) begin
            ok = 0; p_ovf = 1;
          end
          p_fill = 0;
          if (ok) begin
            p_count = cnt; p_double = (magic == MAGIC_D); p_phase = asdd_pkg::PH_TABLE;
          end else p_phase = asdd_pkg::PH_PASS;
          for (int i = 0; i < asdd_pkg::HDR_LEN; i++) begin
            t.data = p_hdr[i];
            t.route = ok ? asdd_pkg::RT_HEADER : asdd_pkg::RT_PASS;
            t.pos = 32'(i);
            outs.push_back(t);
          end
        end
      end
      asdd_pkg::PH_TABLE: begin
        tofs = p_offset - asdd_pkg::HDR_LEN;
        e = tofs / asdd_pkg::ENT_LEN; f = tofs % asdd_pkg::ENT_LEN;
        if (e < p_count && e < MAXE) begin
          if (f < 4) p_kind[e] = {p_kind[e][23:0], it.data};
          else if (f < 8) p_start[e] = {p_start[e][23:0], it.data};
          else p_size[e] = {p_size[e][23:0], it.data};
        end
        t.data = it.data; t.route = asdd_pkg::RT_HEADER; t.pos = p_offset;
        outs.push_back(t);
        if (tofs + 1 >= p_count * asdd_pkg::ENT_LEN) begin
          p_dstart = 0;
          if (p_double)
            for (int i = 0; i < p_count && i < MAXE; i++) begin
              endv = p_start[i] + p_size[i];
              if (endv > p_dstart) p_dstart = endv;
            end
          p_loaded = 1;
          p_phase = asdd_pkg::PH_LOOKUP;
        end
      end
      asdd_pkg::PH_LOOKUP, asdd_pkg::PH_PART: begin
        found = 1;
        if (p_phase == asdd_pkg::PH_LOOKUP) begin
          found = 0;
          for (int i = 0; i < p_count && i < MAXE; i++)
            if (!found && p_start[i] == p_offset && p_size[i] != 0) begin
              p_route = kind_route(p_kind[i]); p_psize = p_size[i]; found = 1;
            end
          if (!found && p_offset == p_dstart) begin
            p_route = asdd_pkg::RT_DATA; p_psize = 32'hFFFF_FFFF; found = 1;
          end
          if (!found) begin
            t.data = it.data; t.route = asdd_pkg::RT_SKIP; t.pos = 0;
            outs.push_back(t);
          end else begin
            p_pdone = 0; p_phase = asdd_pkg::PH_PART;
          end
        end
        if (found) begin
          t.data = it.data; t.route = p_route; t.pos = p_pdone;
          outs.push_back(t);
          p_pdone++;
          if (p_route == asdd_pkg::RT_DATA) p_dwritten++;
          else if (p_route == asdd_pkg::RT_RESOURCE) p_rwritten++;
          if (!(p_route == asdd_pkg::RT_DATA && p_double) && p_pdone == p_psize)
            p_phase = asdd_pkg::PH_LOOKUP;
        end
      end
      default: begin
        p_phase = asdd_pkg::PH_PASS;
        t.data = it.data; t.route = asdd_pkg::RT_PASS; t.pos = p_offset;
        outs.push_back(t);
      end
    endcase
    p_offset++;
    dok = 0; rok = 0; seen_d = 0; seen_r = 0;
    if (p_loaded) begin
      dok = 1;
      for (int i = 0; i < p_count && i < MAXE; i++) begin
        if (!seen_d && p_kind[i] == asdd_pkg::ID_DATA) begin
          seen_d = 1;
          if (!p_double) dok = (p_dwritten == p_size[i]);
        end
        if (!seen_r && p_kind[i] == asdd_pkg::ID_RESOURCE) begin
          seen_r = 1; rok = (p_rwritten == p_size[i]);
        end
      end
    end
    foreach (outs[k]) begin
      outs[k].last = (k == outs.size() - 1);
      outs[k].hok = p_loaded; outs[k].dok = dok; outs[k].rok = rok; outs[k].ovf = p_ovf;
      expected_bytes.push_back(outs[k]);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("mismatch at output %0d: %s got %0h want %0h", bytes_out, what, got, want);
  endtask

  // stimulus builders
  task automatic push_byte(logic [7:0] b, bit sof = 0);
    byte_item_t it;
    it.data = b; it.sof = sof;
    pending_bytes.push_back(it);
  endtask

  task automatic push_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8]);
  endtask

  task automatic push_header(logic [31:0] magic, logic [15:0] cnt, bit corrupt);
    logic [7:0] h[asdd_pkg::HDR_LEN];
    {h[0], h[1], h[2], h[3]} = magic;
    {h[4], h[5], h[6], h[7]} = VERSION;
    for (int i = 8; i < 24; i++) h[i] = 8'h00;
    {h[24], h[25]} = cnt;
    if (corrupt) h[$urandom_range(0, 23)] ^= 8'(1 << $urandom_range(0, 7));
    for (int i = 0; i < asdd_pkg::HDR_LEN; i++) push_byte(h[i], i == 0);
    files_sent++;
  endtask

  // well-formed file: parts after the table, now and then with a two-byte gap, then up to six trailing bytes
  task automatic push_file(bit dbl, int n, int maxsz);
    logic [31:0] ids[MAXE], sz[MAXE], st[MAXE];
    logic [31:0] ofs, tail_end;
    int unsigned pick;
    push_header(dbl ? MAGIC_D : MAGIC_S, 16'(n), 0);
    ofs = 32'(asdd_pkg::HDR_LEN + asdd_pkg::ENT_LEN * n);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0, 1: ids[i] = asdd_pkg::ID_DATA;
        2, 3: ids[i] = asdd_pkg::ID_RESOURCE;
        4: ids[i] = asdd_pkg::ID_COMMENT;
        5: ids[i] = asdd_pkg::ID_DATES;
        6: ids[i] = asdd_pkg::ID_FINDER;
        default: ids[i] = $urandom();
      endcase
      sz[i] = $urandom_range(0, maxsz);
      st[i] = ($urandom_range(0, 9) == 0) ? ofs + 2 : ofs;
      ofs = st[i] + sz[i];
    end
    for (int i = 0; i < n; i++) begin
      push_word(ids[i]); push_word(st[i]); push_word(sz[i]);
    end
    tail_end = ofs + 32'($urandom_range(0, 6));
    for (int i = int'(asdd_pkg::HDR_LEN + asdd_pkg::ENT_LEN * n); i < tail_end; i++)
      push_byte(8'($urandom()));
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0 || pending_bytes.size() == 0) begin
          s_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          byte_item_t it;
          it = pending_bytes.pop_front();
          predict_byte(it);
          s_tvalid <= 1'b1;
          s_tdata <= it.data;
          s_tuser <= it.sof;
        end
      end
    end
  end

  // sink stall and monitor
  int sink_gap = 0;
  always @(posedge clk) begin
    tagged_byte_t w;
    cycles++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          report("unexpected out_byte", 32'(m_tdata[7:0]), 32'd0);
        end else begin
          w = expected_bytes.pop_front();
          if (m_tdata[7:0] != w.data)
            report("out_byte", 32'(m_tdata[7:0]), 32'(w.data));
          if (m_tuser != w.route)
            report("route", 32'(m_tuser), 32'(w.route));
          if (m_tdata[39:8] != w.pos)
            report("part_position", m_tdata[39:8], w.pos);
          if (m_tlast != w.last)
            report("last", 32'(m_tlast), 32'(w.last));
          if (m_tdata[40] != w.hok)
            report("header_ok", 32'(m_tdata[40]), 32'(w.hok));
          if (m_tdata[41] != w.dok)
            report("data_fork_done", 32'(m_tdata[41]), 32'(w.dok));
          if (m_tdata[42] != w.rok)
            report("resource_fork_done", 32'(m_tdata[42]), 32'(w.rok));
          if (m_tdata[43] != w.ovf)
            report("table_overflow", 32'(m_tdata[43]), 32'(w.ovf));
        end
        bytes_out++;
        sink_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
      end
      if (sink_gap > 0) begin
        m_tready <= 1'b0;
        sink_gap--;
      end else m_tready <= 1'b1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_parse();
    // directed: rejected header, overflowing count, AppleDouble, AppleSingle
    push_header(MAGIC_S, 16'h0000, 0);
    repeat (3) push_byte(8'hFF);
    push_header(MAGIC_D, 16'(MAXE + 1), 0);
    push_byte(8'h00);
    push_header(MAGIC_S, 16'hFFFF, 0);
    push_header(MAGIC_S ^ 32'h8000_0000, 16'd1, 0);
    push_file(1, 1, 3);
    push_file(0, 2, 3);
    // restart in the middle of a table
    push_header(MAGIC_S, 16'd2, 0);
    repeat (5) push_byte(8'($urandom()));
    push_file(0, MAXE, 1);
    while (pending_bytes.size() < 450) begin
      case ($urandom_range(0, 9))
        0: push_header($urandom_range(0, 1) ? MAGIC_S : MAGIC_D, 16'($urandom()), 1);
        1: begin
          push_header($urandom(), 16'($urandom()), 0);
          repeat ($urandom_range(0, 5)) push_byte(8'($urandom()));
        end
        default: push_file($urandom_range(0, 1), $urandom_range(1, 5), 12);
      endcase
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_bytes.size() == 0 && !s_tvalid);
    wait (expected_bytes.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d files, checked %0d tagged output bytes", files_sent, bytes_out);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
